/* hdl/pose_heading_error_macros.svh */
// assertion macros used by the pose heading error back stages (phe_finish)
`ifndef POSE_HEADING_ERROR_MACROS_SVH
`define POSE_HEADING_ERROR_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PHE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define PHE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/phe_pkg.sv */
// shared types, constants and elaboration-time functions for the pose heading error block
package phe_pkg;

  // cordic angle width, degrees with 16 fraction bits
  localparam int ZW = 26;
  localparam int HEAD_W = 16;
  localparam int TABLE_LEN = 24;
  localparam logic signed [ZW-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [ZW-1:0] DEG360 = 26'sd23592960;

  // per-item side data carried down the pipeline
  typedef struct packed {
    logic              valid;
    logic              arrived;
    logic              zero;
    logic [HEAD_W-1:0] ch;
    logic [HEAD_W-1:0] th;
  } phe_side_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // inverse cordic gain with 24 fraction bits, evaluated at elaboration
  function automatic logic [23:0] inv_gain(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    p = 64'd1 << 30;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (i < n) p = p + (p >> (2 * i));
    end
    v = p << 30;
    res = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    if (res == 0) res = 64'd1;
    num = (64'd1 << 54) + (res >> 1);
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      q = q << 1;
      if (rem >= res) begin
        rem = rem - res;
        q = q | 64'd1;
      end
    end
    return q[23:0];
  endfunction

  // number of conditional subtract steps to reduce a 16-bit heading by full_turn
  function automatic int red_steps(input int full_turn);
    int s;
    s = 0;
    for (int k = 0; k < 17; k++) begin
      if ((full_turn << k) <= 65535) s = k + 1;
    end
    return s;
  endfunction

endpackage

/* hdl/phe_prep.sv */
// front stages: differences, heading reduction, squares, gain scaling and cordic setup
module phe_prep import phe_pkg::*; #(
  parameter int COORD_BITS = 21,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int N = 16,
  localparam int VW = COORD_BITS + 27,
  localparam int DW = COORD_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [COORD_BITS-1:0]   cur_x,
  input  logic [COORD_BITS-1:0]   cur_y,
  input  logic [HEAD_W-1:0]       cur_heading,
  input  logic [COORD_BITS-1:0]   tgt_x,
  input  logic [COORD_BITS-1:0]   tgt_y,
  input  logic [HEAD_W-1:0]       tgt_heading,
  input  logic [39:0]             rsq,
  output logic signed [VW-1:0]    vx,
  output logic signed [VW-1:0]    vy,
  output logic signed [ZW-1:0]    vz,
  output logic signed [VW-1:0]    rx,
  output logic signed [VW-1:0]    ry,
  output logic signed [ZW-1:0]    rz,
  output phe_side_t               side
);

  localparam int FULL = 360 << ANGLE_FRAC_BITS;
  localparam int STEPS = red_steps(FULL);
  localparam int EW = (DW > 21) ? DW : 21;
  localparam logic signed [24:0] IGS = $signed({1'b0, inv_gain(N)});

  // stage 1: differences and heading reduction
  logic signed [DW-1:0] dx_a, dy_a, dx1, dy1;
  logic [17:0] chr, thr;
  phe_side_t side1;

  always_comb begin
    dx_a = DW'($signed(tgt_x)) - DW'($signed(cur_x));
    dy_a = DW'($signed(tgt_y)) - DW'($signed(cur_y));
    chr = 18'(cur_heading);
    thr = 18'(tgt_heading);
    for (int k = STEPS - 1; k >= 0; k--) begin
      if (chr >= 18'(FULL << k)) chr = chr - 18'(FULL << k);
      if (thr >= 18'(FULL << k)) thr = thr - 18'(FULL << k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid <= 1'b0;
    end else if (en) begin
      side1.valid <= in_valid;
    end
    if (en) begin
      dx1 <= dx_a;
      dy1 <= dy_a;
      side1.arrived <= 1'b0;
      side1.zero <= 1'b0;
      side1.ch <= chr[HEAD_W-1:0];
      side1.th <= thr[HEAD_W-1:0];
    end
  end

  // stage 2: squares for the radius test and gain-scaled offsets
  logic [DW-1:0] ax, ay;
  logic [EW-1:0] axe, aye;
  logic signed [COORD_BITS+25:0] mxa, mya;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [VW-1:0] mx2, my2;
  logic [39:0] pax, pay;
  logic small2;
  phe_side_t side2;

  always_comb begin
    ax = dx1[DW-1] ? DW'(-dx1) : DW'(dx1);
    ay = dy1[DW-1] ? DW'(-dy1) : DW'(dy1);
    axe = EW'(ax);
    aye = EW'(ay);
    mxa = dx1 * IGS;
    mya = dy1 * IGS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side2.valid <= 1'b0;
    end else if (en) begin
      side2.valid <= side1.valid;
    end
    if (en) begin
      side2.arrived <= side1.arrived;
      side2.zero <= side1.zero;
      side2.ch <= side1.ch;
      side2.th <= side1.th;
      dx2 <= dx1;
      dy2 <= dy1;
      mx2 <= VW'(mxa);
      my2 <= VW'(mya);
      pax <= axe[19:0] * axe[19:0];
      pay <= aye[19:0] * aye[19:0];
      small2 <= (axe < EW'(1 << 20)) && (aye < EW'(1 << 20));
    end
  end

  // stage 3: radius test and cordic start values
  logic [40:0] d2;
  logic signed [VW-1:0] sx, sy;
  logic signed [ZW-1:0] h, z0;
  logic signed [VW-1:0] vx_n, vy_n, rx_n, ry_n;
  logic signed [ZW-1:0] vz_n, rz_n;

  always_comb begin
    d2 = 41'(pax) + 41'(pay);
    sx = VW'($signed({dx2, 24'b0}));
    sy = VW'($signed({dy2, 24'b0}));
    if (dx2 < 0) begin
      vx_n = -sx;
      vy_n = -sy;
      vz_n = DEG180;
    end else begin
      vx_n = sx;
      vy_n = sy;
      vz_n = '0;
    end
    h = $signed(ZW'(side2.ch) << (16 - ANGLE_FRAC_BITS));
    z0 = -h;
    if (z0 <= -DEG180) z0 = z0 + DEG360;
    rx_n = mx2;
    ry_n = my2;
    rz_n = z0;
    if (z0 > DEG90) begin
      rx_n = -mx2;
      ry_n = -my2;
      rz_n = z0 - DEG180;
    end else if (z0 < -DEG90) begin
      rx_n = -mx2;
      ry_n = -my2;
      rz_n = z0 + DEG180;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= side2.valid;
    end
    if (en) begin
      side.arrived <= small2 && (d2 < 41'(rsq));
      side.zero <= (dx2 == 0) && (dy2 == 0);
      side.ch <= side2.ch;
      side.th <= side2.th;
      vx <= vx_n;
      vy <= vy_n;
      vz <= vz_n;
      rx <= rx_n;
      ry <= ry_n;
      rz <= rz_n;
    end
  end

endmodule

/* hdl/phe_cordic_stage.sv */
// one registered cordic iteration, vectoring for bearing and rotation for along-track
module phe_cordic_stage import phe_pkg::*; #(
  parameter int I = 0,
  parameter int VW = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic signed [VW-1:0] vx_i,
  input  logic signed [VW-1:0] vy_i,
  input  logic signed [ZW-1:0] vz_i,
  input  logic signed [VW-1:0] rx_i,
  input  logic signed [VW-1:0] ry_i,
  input  logic signed [ZW-1:0] rz_i,
  input  phe_side_t            side_i,
  output logic signed [VW-1:0] vx_o,
  output logic signed [VW-1:0] vy_o,
  output logic signed [ZW-1:0] vz_o,
  output logic signed [VW-1:0] rx_o,
  output logic signed [VW-1:0] ry_o,
  output logic signed [ZW-1:0] rz_o,
  output phe_side_t            side_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_deg(I);

  logic signed [VW-1:0] vxs, vys, rxs, rys;

  // shifted terms
  always_comb begin
    vxs = vx_i >>> I;
    vys = vy_i >>> I;
    rxs = rx_i >>> I;
    rys = ry_i >>> I;
  end

  // micro-rotation, direction from y sign or residual angle
  always_ff @(posedge clk) begin
    if (rst) begin
      side_o.valid <= 1'b0;
    end else if (en) begin
      side_o.valid <= side_i.valid;
    end
    if (en) begin
      side_o.arrived <= side_i.arrived;
      side_o.zero <= side_i.zero;
      side_o.ch <= side_i.ch;
      side_o.th <= side_i.th;
      if (vy_i < 0) begin
        vx_o <= vx_i - vys;
        vy_o <= vy_i + vxs;
        vz_o <= vz_i - ATAN;
      end else begin
        vx_o <= vx_i + vys;
        vy_o <= vy_i - vxs;
        vz_o <= vz_i + ATAN;
      end
      if (rz_i >= 0) begin
        rx_o <= rx_i - rys;
        ry_o <= ry_i + rxs;
        rz_o <= rz_i - ATAN;
      end else begin
        rx_o <= rx_i + rys;
        ry_o <= ry_i - rxs;
        rz_o <= rz_i + ATAN;
      end
    end
  end

endmodule

/* hdl/phe_finish.sv */
// back stages: bearing rounding, target choice, error wrap and along-track saturation
module phe_finish import phe_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int VW = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic signed [VW-1:0] rx,
  input  logic signed [ZW-1:0] vz,
  input  phe_side_t            side,
  output logic                 out_valid,
  output logic [15:0]          heading_error,
  output logic [22:0]          along_track
);

`include "pose_heading_error_macros.svh"

  localparam int AW = (ANGLE_FRAC_BITS + 11 > 18) ? ANGLE_FRAC_BITS + 11 : 18;
  localparam logic signed [AW-1:0] FULL_S = AW'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] HALF_S = AW'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ZW:0] RND = (ZW+1)'(1 << (15 - ANGLE_FRAC_BITS));
  localparam logic signed [VW-1:0] AMAX = VW'(4194303);
  localparam logic signed [VW-1:0] AMIN = -VW'(4194304);
  localparam logic signed [VW-1:0] HALF_UNIT = VW'(1 << 23);

  // stage 1: target angle and saturated along-track
  logic signed [ZW-1:0] bz;
  logic signed [ZW:0] bt;
  logic signed [AW-1:0] tg;
  logic signed [VW-1:0] rs, rsat;
  logic signed [AW-1:0] tg1;
  logic [22:0] at1;
  logic [HEAD_W-1:0] ch1;
  logic f1_v;

  always_comb begin
    bz = vz;
    if (bz > DEG180) bz = bz - DEG360;
    if (side.zero) bz = '0;
    bt = ((ZW+1)'(bz) + RND) >>> (16 - ANGLE_FRAC_BITS);
    tg = AW'(bt);
    if (tg < 0) tg = tg + FULL_S;
    if (tg >= FULL_S) tg = tg - FULL_S;
    if (side.arrived) tg = $signed(AW'(side.th));
    rs = (rx + HALF_UNIT) >>> 24;
    rsat = rs;
    if (rs > AMAX) rsat = AMAX;
    if (rs < AMIN) rsat = AMIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= side.valid;
    end
    if (en) begin
      tg1 <= tg;
      at1 <= rsat[22:0];
      ch1 <= side.ch;
    end
  end

  // stage 2: heading error wrapped to half a turn, output register
  logic signed [AW-1:0] err;

  always_comb begin
    err = tg1 - $signed(AW'(ch1));
    if (err > HALF_S) err = err - FULL_S;
    else if (err < -HALF_S) err = err + FULL_S;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f1_v;
    end
    if (en) begin
      heading_error <= err[15:0];
      along_track <= at1;
    end
  end

  // checks
  `PHE_ASSERT_IMP(a_tgt_range, f1_v, (tg1 >= 0) && (tg1 < FULL_S), "target angle out of turn")
  `PHE_ASSERT_IMP(a_err_range, f1_v, (err <= HALF_S) && (err >= -HALF_S), "error not wrapped")
  `PHE_ASSERT_NXT(a_stall_hold, f1_v && !en, f1_v, "stalled beat lost in back stage")

endmodule

/* hdl/pose_heading_error.sv */
// top level of the pose heading error pipeline
// Each input beat carries a current and a target pose; one result beat per input gives
// the heading error (to the bearing of the target, or to its own heading when it lies
// strictly inside the configured radius, wrapped to +-180 degrees) and the saturated along-track
// distance. The pipeline takes one beat per cycle while the output is not stalled; it has
// three front stages, one register per cordic iteration and two back stages.
// A stall on the output side freezes every stage, and s_tready follows it directly.
module pose_heading_error import phe_pkg::*; #(
  parameter int COORD_BITS = 21,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_ITERATIONS = 16,
  localparam int IN_BITS = 4 * COORD_BITS + 2 * HEAD_W,
  localparam int IN_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic [19:0]     cfg_wdata,
  input  logic            s_tvalid,
  output logic            s_tready,
  // cur_x, cur_y, cur_heading, tgt_x, tgt_y, tgt_heading, zero fill
  input  logic [IN_W-1:0] s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  // heading_error[15:0], along_track[38:16], zero fill
  output logic [39:0]     m_tdata
);

  localparam int N = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
  localparam int VW = COORD_BITS + 27;
  localparam int CB = COORD_BITS;

  // radius register and its square
  logic [19:0] radius;
  logic [39:0] rsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 20'd16;
      rsq <= 40'd256;
    end else begin
      if (cfg_wen) radius <= cfg_wdata;
      rsq <= radius * radius;
    end
  end

  // pipeline advance
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // cordic chain
  logic signed [VW-1:0] vx [0:N];
  logic signed [VW-1:0] vy [0:N];
  logic signed [ZW-1:0] vz [0:N];
  logic signed [VW-1:0] rx [0:N];
  logic signed [VW-1:0] ry [0:N];
  logic signed [ZW-1:0] rz [0:N];
  phe_side_t            sd [0:N];

  phe_prep #(
    .COORD_BITS(COORD_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .N(N)
  ) u_prep (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .cur_x(s_tdata[CB-1:0]),
    .cur_y(s_tdata[2*CB-1:CB]),
    .cur_heading(s_tdata[2*CB+HEAD_W-1:2*CB]),
    .tgt_x(s_tdata[3*CB+HEAD_W-1:2*CB+HEAD_W]),
    .tgt_y(s_tdata[4*CB+HEAD_W-1:3*CB+HEAD_W]),
    .tgt_heading(s_tdata[4*CB+2*HEAD_W-1:4*CB+HEAD_W]),
    .rsq(rsq),
    .vx(vx[0]), .vy(vy[0]), .vz(vz[0]),
    .rx(rx[0]), .ry(ry[0]), .rz(rz[0]),
    .side(sd[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_stage
    phe_cordic_stage #(.I(g), .VW(VW)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .vx_i(vx[g]), .vy_i(vy[g]), .vz_i(vz[g]),
      .rx_i(rx[g]), .ry_i(ry[g]), .rz_i(rz[g]), .side_i(sd[g]),
      .vx_o(vx[g+1]), .vy_o(vy[g+1]), .vz_o(vz[g+1]),
      .rx_o(rx[g+1]), .ry_o(ry[g+1]), .rz_o(rz[g+1]), .side_o(sd[g+1])
    );
  end

  // back stages and output register
  logic [15:0] heading_error;
  logic [22:0] along_track;

  phe_finish #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .VW(VW)) u_finish (
    .clk(clk), .rst(rst), .en(en),
    .rx(rx[N]), .vz(vz[N]), .side(sd[N]),
    .out_valid(m_tvalid),
    .heading_error(heading_error),
    .along_track(along_track)
  );

  assign m_tdata = {1'b0, along_track, heading_error};

endmodule
